@@ hw/rtl/fcba_pkg.sv @@
// Package: shared constants, types and helpers of the chained block allocator.
`default_nettype none

package fcba_pkg;

	// Table geometry
	localparam int          TABLE_WORDS_DEF = 4096;
	localparam logic [15:0] SYSTEM_BLOCKS   = 16'd5;
	localparam logic [15:0] END_MARK        = 16'hFFFF;

	// Reserved table words
	localparam logic [15:0] WORD_UPDATES = 16'd2;
	localparam logic [15:0] WORD_FREE    = 16'd3;
	localparam logic [15:0] WORD_LAST    = 16'd4;

	// Action codes
	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	// Status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOCARD  = 2'd1;
	localparam logic [1:0] STAT_NOSPACE = 2'd2;
	localparam logic [1:0] STAT_BROKEN  = 2'd3;

	// Configuration register indexes and reset values
	localparam logic       REG_CARD  = 1'b0;
	localparam logic       REG_TOTAL = 1'b1;
	localparam logic [12:0] TOTAL_RESET = 13'd4096;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_AL_CHK,
		ST_AL_POS,
		ST_AL_SCAN,
		ST_AL_TAIL,
		ST_AL_W4,
		ST_FR_START,
		ST_FR_WALK,
		ST_FR_W3,
		ST_UPD_W2,
		ST_RD_WAIT,
		ST_FIN
	} state_t;

	// True when b is a data block below the block limit
	function automatic logic is_data(input logic [15:0] b, input logic [16:0] lim);
		is_data = (b >= SYSTEM_BLOCKS) && ({1'b0, b} < lim);
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fat_chain_block_allocator_unit.sv @@
// Chained block allocator: allocation table in RAM with allocate, free and word access.
//
// Usage: items arrive on the input channel (in_valid/in_ready) as an action and its
// operands; each item yields exactly one result beat on the output channel
// (out_valid/out_ready) carrying status, first_block and read_value.
// Configuration (card present, total blocks) must be written through cfg_we/cfg_index/
// cfg_wdata while no item is in flight (the unit does not enforce this) and takes effect for the next item.
// One item is processed at a time; the table RAM has one read and one write port.
// Allocate scans table entries, one entry a cycle; free walks the chain, one link a
// cycle. The scan is bounded by the data block span; the walk ends only at the end
// mark or at a link that is not a data block.
// Reset: control registers clear asynchronously, then a clearing pass writes zero to
// every table word, one word a cycle; no item is taken meanwhile.
// A finished result sits in an output register; the next item is accepted while it
// waits, and a following result holds in its final state until out_ready drains it.
`default_nettype none

module fat_chain_block_allocator_unit
	import fcba_pkg::*;
#(
	parameter int TABLE_WORDS = TABLE_WORDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_wdata,
	// Input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [12:0] block_count,
	input  wire logic [15:0] chain_start,
	input  wire logic [11:0] word_index,
	input  wire logic [15:0] word_value,
	// Output channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [15:0]      first_block,
	output logic [15:0]      read_value
);

	localparam int          AW   = $clog2(TABLE_WORDS);
	localparam logic [16:0] TW17 = 17'(TABLE_WORDS);
	localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_WORDS - 1);

	state_t state_q, state_d;

	// Configuration registers
	logic        card_q;
	logic [12:0] total_q;

	// Clearing pass and output control
	logic [AW-1:0] clr_q;
	logic          out_valid_q;

	// Item payload
	logic [12:0] want_q;
	logic [15:0] blk_q;
	logic        idx_ok_q;
	logic [15:0] cnt3_q;
	logic [1:0]  st_q;
	logic [15:0] head_q;
	logic [15:0] rd_res_q;

	// Allocate scan
	logic [15:0] pos_q;
	logic [16:0] cnt_q;
	logic [15:0] prev_q;
	logic        pend_q;
	logic [15:0] a_s1;
	logic        over_s1;
	logic        vld_s1;

	// Output registers
	logic [1:0]  out_status_q;
	logic [15:0] out_first_q;
	logic [15:0] out_read_q;

	// RAM ports and forwarding
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [15:0]   ram_wdata, ram_rdata, rd_fwd;
	logic          fwd_hit_q;
	logic [15:0]   fwd_data_q;

	// Derived combinational values
	logic [16:0] lim, span;
	logic        idx_ok, accept, out_free;
	logic [15:0] idx16;
	logic [15:0] scan_inc, scan_nxt, scan_data;
	logic [16:0] scan_cnt;
	logic        scan_over, free_hit, scan_done;
	logic        nospace;
	logic        blk_end, blk_bad, nxt_end, nxt_bad;

	fcba_ram #(
		.WIDTH (16),
		.DEPTH (TABLE_WORDS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Block limit and scan span
	always_comb begin
		lim  = ({4'b0, total_q} > TW17) ? TW17 : {4'b0, total_q};
		span = (lim > {1'b0, SYSTEM_BLOCKS}) ? (lim - {1'b0, SYSTEM_BLOCKS}) : 17'd0;
	end

	assign idx16    = {4'b0, word_index};
	assign idx_ok   = {1'b0, idx16} < TW17;
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Use the word written in the read's own cycle over stale RAM data
	assign rd_fwd = fwd_hit_q ? fwd_data_q : ram_rdata;

	// Scan issue and evaluate terms
	always_comb begin
		scan_inc  = pos_q + 16'd1;
		scan_nxt  = is_data(scan_inc, lim) ? scan_inc : SYSTEM_BLOCKS;
		scan_cnt  = cnt_q + 17'd1;
		scan_over = scan_cnt > span;
		scan_data = (pend_q && (a_s1 == prev_q)) ? END_MARK : rd_fwd;
		free_hit  = vld_s1 && !over_s1 && (scan_data == 16'd0);
		scan_done = vld_s1 && (over_s1 || (free_hit && (want_q == 13'd1)));
	end

	// Checks for the allocate start and the free walk
	always_comb begin
		nospace = rd_fwd < {3'b0, want_q};
		blk_end = (blk_q == END_MARK);
		blk_bad = !blk_end && !is_data(blk_q, lim);
		nxt_end = (rd_fwd == END_MARK);
		nxt_bad = !nxt_end && !is_data(rd_fwd, lim);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (action)
						ACT_ALLOC: state_d = card_q ? ST_AL_CHK : ST_FIN;
						ACT_FREE:  state_d = card_q ? ST_FR_START : ST_FIN;
						ACT_READ:  state_d = ST_RD_WAIT;
						default:   state_d = ST_FIN;
					endcase
				end
			end
			ST_AL_CHK:   state_d = nospace ? ST_FIN : ST_AL_POS;
			ST_AL_POS:   state_d = (want_q == 13'd0) ? ST_AL_TAIL : ST_AL_SCAN;
			ST_AL_SCAN: begin
				if (scan_done) state_d = ST_AL_TAIL;
			end
			ST_AL_TAIL:  state_d = (st_q == STAT_BROKEN) ? ST_FIN : ST_AL_W4;
			ST_AL_W4:    state_d = ST_UPD_W2;
			ST_FR_START: state_d = (blk_end || blk_bad) ? ST_FR_W3 : ST_FR_WALK;
			ST_FR_WALK: begin
				if (nxt_end || nxt_bad) state_d = ST_FR_W3;
			end
			ST_FR_W3:    state_d = (st_q == STAT_BROKEN) ? ST_FIN : ST_UPD_W2;
			ST_UPD_W2:   state_d = ST_FIN;
			ST_RD_WAIT:  state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (action)
						ACT_ALLOC, ACT_FREE: begin
							ram_re    = card_q;
							ram_raddr = WORD_FREE[AW-1:0];
						end
						ACT_WRITE: begin
							ram_we    = idx_ok;
							ram_waddr = idx16[AW-1:0];
							ram_wdata = word_value;
						end
						default: begin
							ram_re    = idx_ok;
							ram_raddr = idx16[AW-1:0];
						end
					endcase
				end
			end
			ST_AL_CHK: begin
				ram_we    = !nospace;
				ram_waddr = WORD_FREE[AW-1:0];
				ram_wdata = rd_fwd - {3'b0, want_q};
				ram_re    = !nospace;
				ram_raddr = WORD_LAST[AW-1:0];
			end
			ST_AL_SCAN: begin
				ram_re    = 1'b1;
				ram_raddr = scan_nxt[AW-1:0];
				ram_we    = free_hit && pend_q;
				ram_waddr = prev_q[AW-1:0];
				ram_wdata = a_s1;
			end
			ST_AL_TAIL: begin
				ram_we    = pend_q;
				ram_waddr = prev_q[AW-1:0];
				ram_wdata = END_MARK;
			end
			ST_AL_W4: begin
				ram_we    = 1'b1;
				ram_waddr = WORD_LAST[AW-1:0];
				ram_wdata = prev_q;
				ram_re    = 1'b1;
				ram_raddr = WORD_UPDATES[AW-1:0];
			end
			ST_FR_START: begin
				ram_re    = !(blk_end || blk_bad);
				ram_raddr = blk_q[AW-1:0];
			end
			ST_FR_WALK: begin
				ram_we    = 1'b1;
				ram_waddr = blk_q[AW-1:0];
				ram_wdata = 16'd0;
				ram_re    = !(nxt_end || nxt_bad);
				ram_raddr = rd_fwd[AW-1:0];
			end
			ST_FR_W3: begin
				ram_we    = 1'b1;
				ram_waddr = WORD_FREE[AW-1:0];
				ram_wdata = cnt3_q;
				ram_re    = (st_q != STAT_BROKEN);
				ram_raddr = WORD_UPDATES[AW-1:0];
			end
			ST_UPD_W2: begin
				ram_we    = 1'b1;
				ram_waddr = WORD_UPDATES[AW-1:0];
				ram_wdata = rd_fwd + 16'd1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			card_q      <= 1'b0;
			total_q     <= TOTAL_RESET;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_we) begin
				if (cfg_index == REG_CARD) begin
					card_q <= cfg_wdata[0];
				end else begin
					total_q <= cfg_wdata;
				end
			end
			// Raise on a finished item, drop when the beat is taken
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Forwarding of a write that collides with the read issued in the same cycle
	always_ff @(posedge clk) begin
		fwd_hit_q  <= ram_we && ram_re && (ram_waddr == ram_raddr);
		fwd_data_q <= ram_wdata;
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					want_q   <= block_count;
					blk_q    <= chain_start;
					idx_ok_q <= idx_ok;
					head_q   <= END_MARK;
					rd_res_q <= 16'd0;
					st_q     <= (((action == ACT_ALLOC) || (action == ACT_FREE)) && !card_q)
						? STAT_NOCARD : STAT_OK;
				end
			end
			ST_AL_CHK: begin
				if (nospace) st_q <= STAT_NOSPACE;
			end
			ST_AL_POS: begin
				pos_q  <= rd_fwd;
				prev_q <= rd_fwd;
				pend_q <= 1'b0;
				cnt_q  <= 17'd0;
				vld_s1 <= 1'b0;
			end
			ST_AL_SCAN: begin
				// Issue the next position regardless of the evaluation
				pos_q   <= scan_nxt;
				cnt_q   <= scan_cnt;
				a_s1    <= scan_nxt;
				over_s1 <= scan_over;
				vld_s1  <= 1'b1;
				// Evaluate the entry read last cycle
				if (vld_s1 && over_s1) begin
					st_q <= STAT_BROKEN;
				end else if (free_hit) begin
					if (!pend_q) head_q <= a_s1;
					prev_q <= a_s1;
					pend_q <= 1'b1;
					want_q <= want_q - 13'd1;
				end
			end
			ST_FR_START: begin
				cnt3_q <= rd_fwd;
				if (blk_bad) st_q <= STAT_BROKEN;
			end
			ST_FR_WALK: begin
				cnt3_q <= cnt3_q + 16'd1;
				blk_q  <= rd_fwd;
				if (nxt_bad) st_q <= STAT_BROKEN;
			end
			ST_RD_WAIT: begin
				rd_res_q <= idx_ok_q ? rd_fwd : 16'd0;
			end
			ST_FIN: begin
				if (out_free) begin
					out_status_q <= st_q;
					out_first_q  <= (st_q == STAT_OK) ? head_q : END_MARK;
					out_read_q   <= rd_res_q;
				end
			end
			default: begin
				pend_q <= pend_q;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign first_block = out_first_q;
	assign read_value  = out_read_q;

	// No item is taken during the clearing pass
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("input accepted during clearing pass");

	// A new result beat is loaded only from the final state
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
		else $error("result raised outside final state");

	// An evaluated scan entry always has blocks left to allocate
	a_scan_want: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_AL_SCAN) && vld_s1 && !over_s1) |-> (want_q != 13'd0))
		else $error("scan running with nothing left to allocate");

	// Scan links touch data blocks only
	a_scan_write_data: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_AL_SCAN) && ram_we) |-> is_data(prev_q, lim))
		else $error("scan wrote outside the data blocks");

	// A failed item never reports a chain head
	a_fail_no_head: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q != STAT_OK)) |-> (out_first_q == END_MARK))
		else $error("failed item reports a chain head");

endmodule

`default_nettype wire

@@ hw/rtl/fcba_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module fcba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then read old contents on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
